// ===== rtl/core/temporal_pixel_reducer_core_assert.svh =====
// ----------------------------------------------------------------------------
// temporal pixel reducer assertion macros
// implication checks on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_PIXEL_REDUCER_CORE_ASSERT_SVH
`define TEMPORAL_PIXEL_REDUCER_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TPR_ASSERT_SAME(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |-> (rhs)) \
        else $error("temporal pixel reducer check failed");
// next-cycle implication
`define TPR_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |=> (rhs)) \
        else $error("temporal pixel reducer check failed");
`else
`define TPR_ASSERT_SAME(label, lhs, rhs)
`define TPR_ASSERT_NEXT(label, lhs, rhs)
`endif

`endif

// ===== rtl/core/tpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpr_pkg
// shared constants and types of the temporal pixel reducer
// ----------------------------------------------------------------------------
`default_nettype none

package tpr_pkg;

    localparam int DEF_MAX_IMAGES  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // reducer selection codes
    typedef enum logic [1:0] {
        MODE_MEAN   = 2'd0,
        MODE_MEDIAN = 2'd1,
        MODE_MIN    = 2'd2,
        MODE_MAX    = 2'd3
    } t_mode;

    // per-cycle command to every sort cell
    typedef struct packed {
        logic insert;  // place a new sample in sorted order
        logic shift;   // move every value one cell toward cell zero
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/tpr_sort_cell.sv =====
// ----------------------------------------------------------------------------
// tpr_sort_cell
// one cell of the insertion sort chain, holds one stored sample
// ----------------------------------------------------------------------------
`default_nettype none

module tpr_sort_cell
    import tpr_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire                           i_clk,
    input  wire t_cell_ctrl               i_ctrl,
    input  wire                           i_occupied,
    input  wire logic signed [SAMPLE_BITS-1:0] i_new_val,
    input  wire                           i_prev_greater,
    input  wire logic signed [SAMPLE_BITS-1:0] i_prev_val,
    input  wire logic signed [SAMPLE_BITS-1:0] i_next_val,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic                          o_greater
);

    logic signed [SAMPLE_BITS-1:0] r_val;

    // an empty cell counts as larger than any sample
    assign o_greater = !i_occupied || (r_val > i_new_val);
    assign o_val     = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (o_greater) begin
                r_val <= i_prev_greater ? i_prev_val : i_new_val;
            end
        end else if (i_ctrl.shift) begin
            r_val <= i_next_val;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tpr_divider.sv =====
// ----------------------------------------------------------------------------
// tpr_divider
// restoring signed divider, one quotient bit per step, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module tpr_divider
    import tpr_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int SUM_W       = DEF_SAMPLE_BITS + 6,
    parameter int CNT_W       = 7
) (
    input  wire                           i_clk,
    input  wire                           i_load,
    input  wire                           i_step,
    input  wire logic signed [SUM_W-1:0]  i_dividend,
    input  wire logic [CNT_W-1:0]         i_divisor,
    output logic signed [SAMPLE_BITS-1:0] o_quot
);

    logic [SUM_W-1:0] r_dq;    // dividend bits out at the top, quotient bits in below
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic             r_neg;

    logic [SUM_W-1:0] w_mag;
    logic [CNT_W:0]   w_trial;
    logic             w_ge;
    logic [CNT_W:0]   w_diff;
    logic [SAMPLE_BITS-1:0] w_qmag;

    assign w_mag   = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_trial = {r_rem, r_dq[SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_qmag  = r_dq[SAMPLE_BITS-1:0];
    assign o_quot  = r_neg ? -w_qmag : w_qmag;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dq  <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_dq  <= {r_dq[SUM_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/temporal_pixel_reducer_core.sv =====
// ----------------------------------------------------------------------------
// temporal_pixel_reducer_core
// per-pixel mean, median, minimum or maximum over a series of image samples
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carries one sample request per image
//   (value, valid flag, last flag). output channel: o_out_valid / i_out_stall
//   carries one result request per pixel, made on the request flagged last.
//   i_cfg_we / i_cfg_data write the reducer mode (mean, median, min, max);
//   write it only while no pixel result is pending.
// throughput and finish phase
//   the sorted store is a chain of MAX_IMAGES cells that insert one sample per
//   cycle in order while the input is not stalled. after a last request the
//   input stalls until the finish phase is done and the output register is
//   free; meanwhile the mean divider takes one quotient bit per cycle (SUM_W =
//   SAMPLE_BITS + log2(MAX_IMAGES) bits) while the chain shifts toward cell
//   zero to bring the middle values to the first two cells. the result is
//   loaded into the output register as the input stall ends.
// reset
//   synchronous active-low i_rst_n clears counts, sum, min/max, the mode and
//   the output valid flag; cell contents are not cleared, the count masks them
// stall
//   a held result stays on the output register; the next pixel's samples are
//   still taken, and a later last request waits in the finish phase until the
//   output register is free
// ----------------------------------------------------------------------------
`default_nettype none

`include "temporal_pixel_reducer_core_assert.svh"

module temporal_pixel_reducer_core
    import tpr_pkg::*;
#(
    parameter int MAX_IMAGES  = DEF_MAX_IMAGES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // configuration
    input  wire                           i_cfg_we,
    input  wire logic [1:0]               i_cfg_data,
    // sample requests
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  wire                           i_sample_valid,
    input  wire                           i_last_sample,
    // result requests
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_reduced_value,
    output logic                          o_reduced_valid,
    output logic                          o_samples_dropped
);

    localparam int CNT_W   = $clog2(MAX_IMAGES + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_IMAGES);
    localparam int DSTEP_W = $clog2(SUM_W + 1);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // accumulate samples, then finish one pixel
    typedef enum logic [1:0] {
        S_ACC = 2'b01,
        S_FIN = 2'b10
    } t_state;

    t_state r_state, n_state;

    t_mode                         r_mode;
    logic [CNT_W-1:0]              r_cnt;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic                          r_ovf;
    logic [CNT_W-1:0]              r_shl;    // chain shifts left to do
    logic [DSTEP_W-1:0]            r_dstep;  // divider steps left to do

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_rvalid;
    logic                          r_out_drop;

    logic                          w_in_acc;
    logic                          w_room;
    logic                          w_ins;
    logic                          w_drop;
    logic                          w_start;
    logic                          w_fin_done;
    logic [CNT_W-1:0]              n_cnt;
    logic signed [SUM_W-1:0]       n_sum;
    logic [CNT_W-1:0]              w_cnt_m1;
    t_cell_ctrl                    w_ctrl;

    logic signed [SAMPLE_BITS-1:0] w_val [MAX_IMAGES];
    logic                          w_gt  [MAX_IMAGES];
    logic signed [SAMPLE_BITS-1:0] w_quot;
    logic signed [SAMPLE_BITS:0]   w_mid_sum;
    logic signed [SAMPLE_BITS-1:0] w_median;
    logic signed [SAMPLE_BITS-1:0] w_result;

    // handshake
    assign o_in_stall = (r_state != S_ACC);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // a valid sample beyond the store size is dropped and only flagged
    assign w_room  = r_cnt < CNT_W'(MAX_IMAGES);
    assign w_ins   = w_in_acc && i_sample_valid && w_room;
    assign w_drop  = w_in_acc && i_sample_valid && !w_room;
    assign w_start = w_in_acc && i_last_sample;

    assign n_cnt    = r_cnt + CNT_W'(w_ins);
    assign n_sum    = w_ins ? r_sum + SUM_W'(i_sample_value) : r_sum;
    assign w_cnt_m1 = n_cnt - 1'b1;

    // finish ends when divider and chain are done and the output register is free
    assign w_fin_done = (r_state == S_FIN) && (r_dstep == '0) && (r_shl == '0)
                        && (!r_out_valid || !i_out_stall);

    assign w_ctrl.insert = w_ins;
    assign w_ctrl.shift  = (r_state == S_FIN) && (r_shl != '0);

    // insertion sort chain: cell i is occupied while i is below the count
    for (genvar g = 0; g < MAX_IMAGES; g++) begin : g_cell
        logic                          w_occ;
        logic                          w_pgt;
        logic signed [SAMPLE_BITS-1:0] w_pval;
        logic signed [SAMPLE_BITS-1:0] w_nval;

        assign w_occ = r_cnt > CNT_W'(g);

        if (g == 0) begin : g_first
            assign w_pgt  = 1'b0;
            assign w_pval = i_sample_value;
        end else begin : g_inner
            assign w_pgt  = w_gt[g-1];
            assign w_pval = w_val[g-1];
        end

        if (g == MAX_IMAGES - 1) begin : g_end
            assign w_nval = w_val[g];
        end else begin : g_mid
            assign w_nval = w_val[g+1];
        end

        tpr_sort_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (w_ctrl),
            .i_occupied     (w_occ),
            .i_new_val      (i_sample_value),
            .i_prev_greater (w_pgt),
            .i_prev_val     (w_pval),
            .i_next_val     (w_nval),
            .o_val          (w_val[g]),
            .o_greater      (w_gt[g])
        );
    end

    // mean: sum over count, loaded with the last request's updated totals
    tpr_divider #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_load     (w_start),
        .i_step     ((r_state == S_FIN) && (r_dstep != '0)),
        .i_dividend (n_sum),
        .i_divisor  (n_cnt),
        .o_quot     (w_quot)
    );

    // after the shifts cell zero holds the lower middle value, cell one the upper
    assign w_mid_sum = {w_val[0][SAMPLE_BITS-1], w_val[0]}
                     + {w_val[1][SAMPLE_BITS-1], w_val[1]};
    assign w_median  = r_cnt[0] ? w_val[0] : w_mid_sum[SAMPLE_BITS:1];

    always_comb begin
        case (r_mode)
            MODE_MEAN:   w_result = w_quot;
            MODE_MEDIAN: w_result = w_median;
            MODE_MIN:    w_result = r_min;
            MODE_MAX:    w_result = r_max;
            default:     w_result = r_max;
        endcase
        if (r_cnt == '0) begin
            w_result = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ACC: begin
                if (w_start) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_fin_done) begin
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    // control and pixel totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_mode      <= MODE_MEAN;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_min       <= SAMPLE_MAX;
            r_max       <= SAMPLE_MIN;
            r_ovf       <= 1'b0;
            r_shl       <= '0;
            r_dstep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_mode <= t_mode'(i_cfg_data);
            end

            if (w_ins) begin
                r_cnt <= n_cnt;
                r_sum <= n_sum;
                if (i_sample_value < r_min) begin
                    r_min <= i_sample_value;
                end
                if (i_sample_value > r_max) begin
                    r_max <= i_sample_value;
                end
            end
            if (w_drop) begin
                r_ovf <= 1'b1;
            end

            // finish counters
            if (w_start) begin
                r_shl   <= (n_cnt == '0) ? '0 : (w_cnt_m1 >> 1);
                r_dstep <= DSTEP_W'(SUM_W);
            end else if (r_state == S_FIN) begin
                if (r_shl != '0) begin
                    r_shl <= r_shl - 1'b1;
                end
                if (r_dstep != '0) begin
                    r_dstep <= r_dstep - 1'b1;
                end
            end

            // a new result loads, otherwise a taken result leaves
            if (w_fin_done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_fin_done) begin
                r_cnt       <= '0;
                r_sum       <= '0;
                r_min       <= SAMPLE_MAX;
                r_max       <= SAMPLE_MIN;
                r_ovf       <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_fin_done) begin
            r_out_value  <= w_result;
            r_out_rvalid <= (r_cnt != '0);
            r_out_drop   <= r_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_reduced_value   = r_out_value;
    assign o_reduced_valid   = r_out_rvalid;
    assign o_samples_dropped = r_out_drop;

    // checks
    `TPR_ASSERT_SAME(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(MAX_IMAGES))
    `TPR_ASSERT_NEXT(a_last_enters_fin, w_start, r_state == S_FIN)
    `TPR_ASSERT_SAME(a_result_from_fin, $rose(r_out_valid), $past(r_state == S_FIN))
    `TPR_ASSERT_NEXT(a_clear_after_fin, w_fin_done, (r_cnt == '0) && !r_ovf)

endmodule

`default_nettype wire
